[rtl/aff_pkg.sv]
// ----------------------------------------------------------------------------
// Addressed frame filter package
// Shared types and constants for the addressed frame filter.
// ----------------------------------------------------------------------------
package aff_pkg;

    // Packet walk phases.
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_DEST = 3'd1,
        PH_SRC  = 3'd2,
        PH_LOW  = 3'd3,
        PH_HIGH = 3'd4
    } t_phase;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_WORD      = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_TYPE  = 3'd2,
        ST_NOT_ADDR  = 3'd3,
        ST_BAD_LEN   = 3'd4
    } t_status;

    // Configuration register indexes.
    localparam logic CFG_LOCAL_ADDR = 1'b0;
    localparam logic CFG_BCAST_ADDR = 1'b1;

    localparam logic [7:0] LOCAL_ADDR_RESET = 8'd0;
    localparam logic [7:0] BCAST_ADDR_RESET = 8'd255;

    // Header limits.
    localparam logic [7:0] MIN_LENGTH  = 8'd4;
    localparam logic [7:0] HEADER_LEN  = 8'd3;
    localparam logic [7:0] TYPE_MIN    = 8'd1;
    localparam logic [7:0] TYPE_MAX    = 8'd4;
    localparam logic [7:0] WORD_BYTES  = 8'd2;

endpackage

[rtl/aff_in_if.sv]
// ----------------------------------------------------------------------------
// Addressed frame filter byte channel
// Valid/ready channel carrying one received packet byte per request.
// ----------------------------------------------------------------------------
interface aff_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       packet_start;
    logic [7:0] packet_length;

    modport source (output valid, output rx_byte, output packet_start,
                    output packet_length, input ready);
    modport sink   (input valid, input rx_byte, input packet_start,
                    input packet_length, output ready);
endinterface

[rtl/aff_out_if.sv]
// ----------------------------------------------------------------------------
// Addressed frame filter result channel
// Valid/ready channel carrying one payload word or rejection per request.
// ----------------------------------------------------------------------------
interface aff_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] payload_word;
    logic [2:0]  message_type;
    logic [7:0]  src_addr;
    logic [6:0]  word_index;
    logic        last_word;

    modport source (output valid, output status, output payload_word,
                    output message_type, output src_addr,
                    output word_index, output last_word, input ready);
    modport sink   (input valid, input status, input payload_word,
                    input message_type, input src_addr,
                    input word_index, input last_word, output ready);
endinterface

[rtl/addressed_frame_filter_core.sv]
// ----------------------------------------------------------------------------
// Addressed frame filter core
// Checks packet headers against the node address and pairs payload bytes
// into 16-bit words, one result request per word or per rejected packet.
// ----------------------------------------------------------------------------
// A result appears on o_res in the cycle after the byte that causes it is
// accepted. Throughput: one byte per cycle; the single output register
// sets this, and it takes a new byte whenever it is empty or being drained.
// Reset (synchronous, active low) returns the walk to idle, clears the held
// header fields and restores the local address to 0 and broadcast to 255.
// ----------------------------------------------------------------------------
module addressed_frame_filter_core
    import aff_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [7:0]   i_cfg_data,
    aff_in_if.sink       i_rx,
    aff_out_if.source    o_res
);

    // Walk state and configuration.
    t_phase      r_phase,        n_phase;
    logic [2:0]  r_held_type,    n_held_type;
    logic [7:0]  r_held_sender,  n_held_sender;
    logic [7:0]  r_payload_left, n_payload_left;
    logic        r_length_ok,    n_length_ok;
    logic [7:0]  r_low_byte,     n_low_byte;
    logic [6:0]  r_word_count,   n_word_count;
    logic [7:0]  r_local_addr;
    logic [7:0]  r_bcast_addr;

    // Output register.
    logic        r_out_valid;
    t_status     r_status,       n_status;
    logic [15:0] r_payload_word, n_payload_word;
    logic [2:0]  r_msg_type,     n_msg_type;
    logic [7:0]  r_sender,       n_sender;
    logic [6:0]  r_word_index,   n_word_index;
    logic        r_last_word,    n_last_word;
    logic        n_res_valid;

    logic        accept;
    logic [7:0]  rx_b;
    logic        len_short;
    logic        type_bad;
    logic        addr_ok;
    logic [7:0]  len_payload;
    logic [7:0]  left_dec;
    logic        last;

    // A byte is taken whenever the output register is empty or being drained.
    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign accept     = i_rx.valid && i_rx.ready;
    assign rx_b       = i_rx.rx_byte;

    // Header checks, in the order they are applied.
    assign len_short   = i_rx.packet_length < MIN_LENGTH;
    assign type_bad    = (rx_b < TYPE_MIN) || (rx_b > TYPE_MAX);
    assign addr_ok     = (rx_b == r_local_addr) || (rx_b == r_bcast_addr);
    assign len_payload = i_rx.packet_length - HEADER_LEN;

    // Remaining payload after this word, held at zero rather than wrapping.
    assign left_dec = (r_payload_left >= WORD_BYTES) ? r_payload_left - WORD_BYTES
                                                     : 8'd0;
    assign last     = left_dec == 8'd0;

    // Next phase. A start byte always opens a new packet, abandoning any
    // packet in progress.
    always_comb begin
        n_phase = PH_IDLE;
        if (i_rx.packet_start) begin
            n_phase = (len_short || type_bad) ? PH_IDLE : PH_DEST;
        end else begin
            unique case (r_phase)
                PH_DEST: n_phase = addr_ok ? PH_SRC : PH_IDLE;
                PH_SRC:  n_phase = r_length_ok ? PH_LOW : PH_IDLE;
                PH_LOW:  n_phase = PH_HIGH;
                PH_HIGH: n_phase = last ? PH_IDLE : PH_LOW;
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // Held fields and the result produced by the current byte.
    always_comb begin
        n_held_type    = r_held_type;
        n_held_sender  = r_held_sender;
        n_payload_left = r_payload_left;
        n_length_ok    = r_length_ok;
        n_low_byte     = r_low_byte;
        n_word_count   = r_word_count;
        n_res_valid    = 1'b0;
        n_status       = ST_WORD;
        n_payload_word = 16'd0;
        n_msg_type     = 3'd0;
        n_sender       = 8'd0;
        n_word_index   = 7'd0;
        n_last_word    = 1'b0;

        if (i_rx.packet_start) begin
            n_word_count  = 7'd0;
            n_low_byte    = 8'd0;
            n_held_sender = 8'd0;
            if (len_short || type_bad) begin
                n_payload_left = 8'd0;
                n_length_ok    = 1'b0;
                n_held_type    = 3'd0;
                n_res_valid    = 1'b1;
                n_status       = len_short ? ST_SHORT : ST_BAD_TYPE;
            end else begin
                n_held_type    = rx_b[2:0];
                n_payload_left = len_payload;
                n_length_ok    = !len_payload[0];
            end
        end else begin
            unique case (r_phase)
                PH_DEST: begin
                    if (!addr_ok) begin
                        n_held_type = 3'd0;
                        n_res_valid = 1'b1;
                        n_status    = ST_NOT_ADDR;
                    end
                end
                PH_SRC: begin
                    n_held_sender = rx_b;
                    if (!r_length_ok) begin
                        // An odd payload is reported with the sender it names.
                        n_held_type = 3'd0;
                        n_res_valid = 1'b1;
                        n_status    = ST_BAD_LEN;
                        n_sender    = rx_b;
                    end
                end
                PH_LOW: begin
                    n_low_byte = rx_b;
                end
                PH_HIGH: begin
                    n_payload_left = left_dec;
                    n_res_valid    = 1'b1;
                    n_status       = ST_WORD;
                    n_payload_word = {rx_b, r_low_byte};
                    n_msg_type     = r_held_type;
                    n_sender       = r_held_sender;
                    n_word_index   = r_word_count;
                    n_last_word    = last;
                    n_word_count   = r_word_count + 7'd1;
                end
                default: begin
                    // Stray bytes outside a packet are dropped.
                end
            endcase
        end
    end

    // State and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_held_type    <= 3'd0;
            r_held_sender  <= 8'd0;
            r_payload_left <= 8'd0;
            r_length_ok    <= 1'b0;
            r_low_byte     <= 8'd0;
            r_word_count   <= 7'd0;
            r_local_addr   <= LOCAL_ADDR_RESET;
            r_bcast_addr   <= BCAST_ADDR_RESET;
        end else begin
            if (accept) begin
                r_phase        <= n_phase;
                r_held_type    <= n_held_type;
                r_held_sender  <= n_held_sender;
                r_payload_left <= n_payload_left;
                r_length_ok    <= n_length_ok;
                r_low_byte     <= n_low_byte;
                r_word_count   <= n_word_count;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LOCAL_ADDR: r_local_addr <= i_cfg_data;
                    CFG_BCAST_ADDR: r_bcast_addr <= i_cfg_data;
                    default:        r_local_addr <= r_local_addr;
                endcase
            end
        end
    end

    // Output register: loaded by a byte that yields a result, emptied when
    // the downstream side takes the request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && n_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_res_valid) begin
            r_status       <= n_status;
            r_payload_word <= n_payload_word;
            r_msg_type     <= n_msg_type;
            r_sender       <= n_sender;
            r_word_index   <= n_word_index;
            r_last_word    <= n_last_word;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_status;
    assign o_res.payload_word = r_payload_word;
    assign o_res.message_type = r_msg_type;
    assign o_res.src_addr     = r_sender;
    assign o_res.word_index   = r_word_index;
    assign o_res.last_word    = r_last_word;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Addressed frame filter core testbench
// Feeds packet bytes through the byte channel and checks every word or
// rejection on the result channel against a cycle-free predictor of the
// header checks and word pairing. Covers directed corner packets, then
// random well-formed and broken packets under four address settings and
// four mixes of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_top;
    import aff_pkg::*;

    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 4;
    localparam int BYTES_PER_SETTING = 200;

    // Address settings and idle mixes, one entry per random phase.
    localparam logic [7:0] LOCAL_SET [4] = '{8'h5A, 8'hFF, 8'h00, 8'h81};
    localparam logic [7:0] BCAST_SET [4] = '{8'hFF, 8'h00, 8'h00, 8'h7E};
    localparam int SEND_IDLE_SET [4] = '{0, 59, 0, 13};
    localparam int RECV_STALL_SET [4] = '{0, 0, 59, 13};

    // One word or rejection as it leaves the block.
    typedef struct packed {
        t_status     status;
        logic [15:0] word;
        logic [2:0]  msg_type;
        logic [7:0]  sender;
        logic [6:0]  word_idx;
        logic        is_last;
    } t_frame_result;

    // ------------------------------------------------------------------------
    // Predicts the filter's results from each accepted byte and holds them
    // until the block produces the matching result request.
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        t_phase        phase;
        logic [2:0]    held_type;
        logic [7:0]    held_sender;
        logic [7:0]    payload_left;
        logic          length_ok;
        logic [7:0]    low_byte;
        logic [6:0]    word_count;
        logic [7:0]    local_addr;
        logic [7:0]    bcast_addr;
        t_frame_result expected_q[$];
        int            failures;
        int            bytes_used;
        int            per_status[5];

        function new();
            phase = PH_IDLE;
            held_type = '0;
            held_sender = '0;
            payload_left = '0;
            length_ok = 1'b0;
            low_byte = '0;
            word_count = '0;
            local_addr = LOCAL_ADDR_RESET;
            bcast_addr = BCAST_ADDR_RESET;
            failures = 0;
            bytes_used = 0;
            foreach (per_status[i]) per_status[i] = 0;
        endfunction

        function void set_addresses(logic [7:0] local_value, logic [7:0] bcast_value);
            local_addr = local_value;
            bcast_addr = bcast_value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // A rejection ends the packet: the walk returns to idle.
        function void queue_rejection(t_status code, logic [7:0] sender);
            t_frame_result r;
            r = '0;
            r.status = code;
            r.sender = sender;
            expected_q.push_back(r);
            held_type = '0;
            phase = PH_IDLE;
        endfunction

        function void note_byte(logic [7:0] rx_value, logic start, logic [7:0] length);
            t_frame_result r;
            logic          is_last;
            // Bytes that arrive while idle without a start are dropped silently.
            if (start || phase != PH_IDLE) begin
                bytes_used++;
            end
            if (start) begin
                // A start always opens a new packet, even in the middle of one.
                word_count = '0;
                low_byte = '0;
                held_sender = '0;
                if (length < MIN_LENGTH) begin
                    payload_left = '0;
                    length_ok = 1'b0;
                    queue_rejection(ST_SHORT, 8'h00);
                end else if (rx_value < TYPE_MIN || rx_value > TYPE_MAX) begin
                    payload_left = '0;
                    length_ok = 1'b0;
                    queue_rejection(ST_BAD_TYPE, 8'h00);
                end else begin
                    held_type = rx_value[2:0];
                    payload_left = length - HEADER_LEN;
                    length_ok = ~payload_left[0];
                    phase = PH_DEST;
                end
            end else begin
                case (phase)
                    PH_DEST: begin
                        if (rx_value != local_addr && rx_value != bcast_addr) begin
                            queue_rejection(ST_NOT_ADDR, 8'h00);
                        end else begin
                            phase = PH_SRC;
                        end
                    end
                    PH_SRC: begin
                        // The sender is already known when an odd payload is flagged.
                        held_sender = rx_value;
                        if (!length_ok) begin
                            queue_rejection(ST_BAD_LEN, held_sender);
                        end else begin
                            phase = PH_LOW;
                        end
                    end
                    PH_LOW: begin
                        low_byte = rx_value;
                        phase = PH_HIGH;
                    end
                    PH_HIGH: begin
                        payload_left = (payload_left >= WORD_BYTES) ?
                                       payload_left - WORD_BYTES : 8'd0;
                        is_last = (payload_left == 8'd0);
                        r.status = ST_WORD;
                        r.word = {rx_value, low_byte};
                        r.msg_type = held_type;
                        r.sender = held_sender;
                        r.word_idx = word_count;
                        r.is_last = is_last;
                        expected_q.push_back(r);
                        word_count = word_count + 7'd1;
                        phase = is_last ? PH_IDLE : PH_LOW;
                    end
                    default: begin
                        phase = PH_IDLE;
                    end
                endcase
            end
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("Result with nothing expected: status %0d word %h sender %h",
                             got.status, got.word, got.sender);
                end
            end else begin
                want = expected_q.pop_front();
                per_status[want.status]++;
                if (got.status !== want.status || got.word !== want.word ||
                        got.msg_type !== want.msg_type || got.sender !== want.sender ||
                        got.word_idx !== want.word_idx || got.is_last !== want.is_last) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("Result mismatch: expected status %0d word %h type %0d ",
                                 want.status, want.word, want.msg_type,
                                 "sender %h index %0d last %0b", want.sender,
                                 want.word_idx, want.is_last);
                        $display("                 got      status %0d word %h type %0d ",
                                 got.status, got.word, got.msg_type,
                                 "sender %h index %0d last %0b", got.sender,
                                 got.word_idx, got.is_last);
                    end
                end
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_index;
    logic [7:0] i_cfg_data;

    aff_in_if  rx_if ();
    aff_out_if res_if ();

    frame_scoreboard sb;

    // Percentages used by the sender and the receiver; the main sequence
    // changes them between phases.
    int send_idle_pct;
    int recv_stall_pct;
    // Remaining cycles of a forced receiver hold-off.
    int hold_left;

    addressed_frame_filter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx        (rx_if),
        .o_res       (res_if)
    );

    always #5 i_clk = ~i_clk;

    // The receiver decides its ready once per cycle. A hold-off keeps it low
    // for a counted stretch so that the output register fills and the block
    // has to push back on the byte channel.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Both channels are observed at the clock edge, before any of this
    // edge's updates land. A result leaving the block always belongs to a
    // byte accepted at an earlier edge, so it is checked first.
    always @(posedge i_clk) begin
        t_frame_result got;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got.status = t_status'(res_if.status);
                got.word = res_if.payload_word;
                got.msg_type = res_if.message_type;
                got.sender = res_if.src_addr;
                got.word_idx = res_if.word_index;
                got.is_last = res_if.last_word;
                sb.check_result(got);
            end
            if (rx_if.valid && rx_if.ready) begin
                sb.note_byte(rx_if.rx_byte, rx_if.packet_start, rx_if.packet_length);
            end
        end
    end

    // Offers one byte, after a random number of idle cycles, and returns at
    // the edge where the request is taken. Valid is left high so that the
    // next byte can follow without a gap.
    task automatic send_byte(input logic [7:0] rx_value, input logic start,
                             input logic [7:0] length);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= rx_value;
        rx_if.packet_start <= start;
        rx_if.packet_length <= length;
        @(posedge i_clk);
        while (!rx_if.ready) begin
            @(posedge i_clk);
        end
    endtask

    // Sends the first n_bytes of a packet: type with length, destination,
    // sender, then random payload. A count below the length cuts the packet
    // short; a count above it adds stray bytes.
    task automatic send_packet(input logic [7:0] ptype, input logic [7:0] plen,
                               input logic [7:0] dest, input logic [7:0] src,
                               input int n_bytes);
        for (int i = 0; i < n_bytes; i++) begin
            case (i)
                0: send_byte(ptype, 1'b1, plen);
                1: send_byte(dest, 1'b0, 8'($urandom_range(255)));
                2: send_byte(src, 1'b0, 8'($urandom_range(255)));
                default: send_byte(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)));
            endcase
        end
    endtask

    // Stops offering and waits until every predicted result has been
    // collected, then lets the block settle. The first edge lets the
    // monitor note the byte taken at the edge just passed.
    task automatic wait_for_results();
        int waited;
        waited = 0;
        rx_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both address registers, local first, then broadcast.
    task automatic write_addresses(input logic [7:0] local_value,
                                   input logic [7:0] bcast_value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_LOCAL_ADDR;
        i_cfg_data <= local_value;
        @(posedge i_clk);
        i_cfg_index <= CFG_BCAST_ADDR;
        i_cfg_data <= bcast_value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_addresses(local_value, bcast_value);
    endtask

    // Most packets are well formed with random content so that the word
    // pairing is exercised deeply; the rest break one check each, or are
    // plain noise. Some packets are cut short by the next start, and some
    // are followed by stray bytes.
    task automatic random_packet();
        int         kind;
        int         n_bytes;
        int         pairs;
        logic [7:0] ptype;
        logic [7:0] plen;
        logic [7:0] dest;
        kind = $urandom_range(99);
        ptype = 8'($urandom_range(4, 1));
        dest = $urandom_range(1) ? sb.local_addr : sb.bcast_addr;
        // Mostly short payloads, now and then one up to the largest length.
        pairs = ($urandom_range(99) < 4) ? $urandom_range(126, 1) : $urandom_range(8, 1);
        plen = 8'(3 + 2 * pairs);
        if (kind >= 92) begin
            repeat ($urandom_range(4, 1)) begin
                send_byte(8'($urandom_range(255)), ($urandom_range(3) == 0),
                          8'($urandom_range(255)));
            end
        end else begin
            if (kind >= 72 && kind < 77) begin
                plen = 8'($urandom_range(3));
            end else if (kind >= 77 && kind < 82) begin
                ptype = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255, 5));
            end else if (kind >= 82 && kind < 87) begin
                do begin
                    dest = 8'($urandom_range(255));
                end while (dest == sb.local_addr || dest == sb.bcast_addr);
            end else if (kind >= 87) begin
                // Even total length leaves an odd payload.
                plen = 8'(4 + 2 * $urandom_range(125));
            end
            n_bytes = (plen == 8'd0) ? 1 : int'(plen);
            if (n_bytes > 1 && $urandom_range(99) < 8) begin
                n_bytes = $urandom_range(n_bytes - 1, 1);
            end
            if ($urandom_range(99) < 5) begin
                n_bytes += $urandom_range(3, 1);
            end
            send_packet(ptype, plen, dest, 8'($urandom_range(255)), n_bytes);
        end
    endtask

    initial begin
        int  target;
        bit  paused;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_LOCAL_ADDR;
        i_cfg_data = 8'h00;
        rx_if.valid = 1'b0;
        rx_if.rx_byte = 8'h00;
        rx_if.packet_start = 1'b0;
        rx_if.packet_length = 8'h00;
        res_if.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        paused = 1'b0;
        sb = new();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corner packets with the reset addresses: local 0,
        // broadcast 255. A zero length fails the length check before the
        // bad type is looked at; length three is one short of the minimum.
        send_packet(8'h00, 8'h00, 8'h00, 8'h00, 1);
        send_packet(8'h01, 8'h03, 8'h00, 8'h00, 1);
        // Types just below and far above the accepted range.
        send_packet(8'h00, 8'h05, 8'h00, 8'h00, 1);
        send_packet(8'hFF, 8'hFF, 8'h00, 8'h00, 1);
        // A destination that is neither this node nor broadcast.
        send_packet(8'h01, 8'h05, 8'h11, 8'h00, 2);
        // An odd payload, rejected only once the sender byte has arrived.
        send_packet(8'h02, 8'h04, 8'h00, 8'hA5, 3);
        // A stray byte while idle must produce nothing.
        send_byte(8'hC3, 1'b0, 8'hFF);
        // A packet that is abandoned after its first word by a new start.
        send_packet(8'h01, 8'h09, 8'h00, 8'h01, 5);
        // Broadcast packet with all-zero and all-one payload words.
        send_byte(8'h04, 1'b1, 8'h07);
        send_byte(8'hFF, 1'b0, 8'h00);
        send_byte(8'hFF, 1'b0, 8'h00);
        send_byte(8'h00, 1'b0, 8'h00);
        send_byte(8'h00, 1'b0, 8'h00);
        send_byte(8'hFF, 1'b0, 8'h00);
        send_byte(8'hFF, 1'b0, 8'h00);
        // The smallest good packet: one word, which is also the last.
        send_packet(8'h03, 8'h05, 8'h00, 8'h00, 5);

        // Random phases, each under its own addresses and idle mix.
        for (int p = 0; p < 4; p++) begin
            wait_for_results();
            write_addresses(LOCAL_SET[p], BCAST_SET[p]);
            send_idle_pct = SEND_IDLE_SET[p];
            recv_stall_pct = RECV_STALL_SET[p];
            if (p == 0) begin
                // Hold the receiver off while a long packet keeps coming,
                // so that the block fills up and refuses bytes for a while.
                hold_left = 60;
                send_packet(8'h01, 8'd63, sb.bcast_addr, 8'($urandom_range(255)), 63);
            end
            target = sb.bytes_used + BYTES_PER_SETTING;
            while (sb.bytes_used < target) begin
                random_packet();
                if (p == 1 && !paused && sb.bytes_used >= target - BYTES_PER_SETTING / 2) begin
                    // The sender pauses until every outstanding result is in.
                    wait_for_results();
                    paused = 1'b1;
                end
            end
        end
        wait_for_results();

        if (sb.pending() != 0) begin
            sb.failures++;
            $display("%0d predicted results never arrived", sb.pending());
        end
        $display("Covered %0d packet bytes under four address settings and idle mixes,",
                 sb.bytes_used);
        $display("checking %0d words and rejections short %0d, type %0d, address %0d, length %0d.",
                 sb.per_status[ST_WORD], sb.per_status[ST_SHORT],
                 sb.per_status[ST_BAD_TYPE], sb.per_status[ST_NOT_ADDR],
                 sb.per_status[ST_BAD_LEN]);
        if (sb.failures == 0) begin
            $display("[addressed_frame_filter_core] OK");
        end else begin
            $display("[addressed_frame_filter_core] ERROR");
        end
        $finish;
    end

    // Guards against a hung handshake; far above the slowest correct run.
    initial begin
        #3000000;
        $display("[addressed_frame_filter_core] ERROR");
        $finish;
    end

endmodule
